>>> rtl/core/frc_pkg.sv
// shared types, constants and helpers for the fifo replacement cache
// no dependencies; used by every file under rtl/core but frc_ram
package frc_pkg;

    localparam int WORD_W = 10;
    localparam int CAP_W  = 10;
    localparam int CNT_W  = 32;

    localparam int WORD_MAX = (1 << WORD_W) - 1;

    localparam int DEF_RING_DEPTH = 1024;
    localparam int DEF_WORD_SPACE = 1024;

    localparam logic [CNT_W-1:0] MISS_MAX = '1;

    // compare-subtract steps that bring any word below ws
    function automatic int red_steps(input int ws);
        int n;
        n = 0;
        for (int k = 0; k < 11; k++)
        begin
            if ((ws << k) <= WORD_MAX)
            begin
                n = k + 1;
            end
        end
        return n;
    endfunction

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_LOOKUP,
        ST_DECIDE,
        ST_CHECK,
        ST_EVICT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clr_step;
        logic accept;
        logic red_step;
        logic look;
        logic decide;
        logic append;
        logic evict_rd;
        logic evict_wr;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic red_skip;
        logic red_last;
        logic hit;
        logic over_cap;
        logic out_free;
    } status_t;

endpackage

>>> rtl/core/frc_if.sv
// handshake channels of the fifo replacement cache: lookup, result, capacity write
// depends on frc_pkg
interface frc_word_if;
    logic                       valid;
    logic                       ready;
    logic [frc_pkg::WORD_W-1:0] word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

interface frc_result_if;
    logic                       valid;
    logic                       ready;
    logic                       hit;
    logic                       evicted_valid;
    logic [frc_pkg::WORD_W-1:0] evicted_word;
    logic [frc_pkg::CNT_W-1:0]  miss_count;

    modport source (output valid, output hit, output evicted_valid, output evicted_word,
                    output miss_count, input ready);
    modport sink   (input valid, input hit, input evicted_valid, input evicted_word,
                    input miss_count, output ready);
endinterface

interface frc_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [frc_pkg::CAP_W-1:0] capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

>>> rtl/core/fifo_replacement_cache_miss_counter.sv
// fifo replacement cache with saturating miss counter, one item in flight at a time
// sequence: a hit runs idle, lookup and decide; a miss adds a capacity check and an evict
//   step per evicted word, with reduce steps first when WORD_SPACE is below 1024; the next
//   item is taken after a result is registered, paced by presence ram read-then-write
// reset: async active low; a clearing pass over all WORD_SPACE addresses zeroes the presence
//   ram before the first item is taken, capacity returns to 1 and the miss count to zero
// depends on frc_pkg, frc_if, frc_ram, frc_ctrl and frc_dp
module fifo_replacement_cache_miss_counter #(
    parameter int RING_DEPTH = frc_pkg::DEF_RING_DEPTH,
    parameter int WORD_SPACE = frc_pkg::DEF_WORD_SPACE
) (
    input  logic         clk,
    input  logic         rst_n,
    frc_word_if.sink     req,
    frc_result_if.source rsp,
    frc_cfg_if.sink      cfg
);

    // command and status bundles between sequencer and datapath
    frc_pkg::cmd_t    cmd;
    frc_pkg::status_t status;

    // sequencer: clearing sweep, reduce, lookup, append, eviction loop, result hand-off
    frc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: presence ram, ring ram, pointers, occupancy, capacity, output register
    frc_dp #(
        .RING_DEPTH (RING_DEPTH),
        .WORD_SPACE (WORD_SPACE)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .status  (status),
        .in_word (req.word),
        .rsp     (rsp),
        .cfg     (cfg)
    );

endmodule

>>> rtl/core/frc_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module frc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/frc_ctrl.sv
// sequencer of the fifo replacement cache: clearing pass, reduce, lookup, append, eviction
// depends on frc_pkg
module frc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  frc_pkg::status_t status,
    output frc_pkg::cmd_t    cmd
);

    frc_pkg::state_t state_reg;
    frc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= frc_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            frc_pkg::ST_CLEAR:
            begin
                if (status.clr_last)
                begin
                    state_next = frc_pkg::ST_IDLE;
                end
            end
            frc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.red_skip ? frc_pkg::ST_LOOKUP : frc_pkg::ST_REDUCE;
                end
            end
            frc_pkg::ST_REDUCE:
            begin
                if (status.red_last)
                begin
                    state_next = frc_pkg::ST_LOOKUP;
                end
            end
            frc_pkg::ST_LOOKUP:
            begin
                state_next = frc_pkg::ST_DECIDE;
            end
            frc_pkg::ST_DECIDE:
            begin
                if (!status.hit)
                begin
                    state_next = frc_pkg::ST_CHECK;
                end
                else if (status.out_free)
                begin
                    state_next = frc_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = frc_pkg::ST_FINISH;
                end
            end
            frc_pkg::ST_CHECK,
            frc_pkg::ST_EVICT:
            begin
                if (status.over_cap)
                begin
                    state_next = frc_pkg::ST_EVICT;
                end
                else if (status.out_free)
                begin
                    state_next = frc_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = frc_pkg::ST_FINISH;
                end
            end
            frc_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = frc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = frc_pkg::ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            frc_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            frc_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            frc_pkg::ST_REDUCE:
            begin
                cmd.red_step = 1'b1;
            end
            frc_pkg::ST_LOOKUP:
            begin
                cmd.look = 1'b1;
            end
            frc_pkg::ST_DECIDE:
            begin
                cmd.decide   = 1'b1;
                cmd.append   = !status.hit;
                cmd.load_out = status.hit && status.out_free;
            end
            frc_pkg::ST_CHECK:
            begin
                cmd.evict_rd = status.over_cap;
                cmd.load_out = !status.over_cap && status.out_free;
            end
            frc_pkg::ST_EVICT:
            begin
                cmd.evict_wr = 1'b1;
                cmd.evict_rd = status.over_cap;
                cmd.load_out = !status.over_cap && status.out_free;
            end
            frc_pkg::ST_FINISH:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> rtl/core/frc_dp.sv
// datapath of the fifo replacement cache: presence ram, ring ram, pointers, counters
// depends on frc_pkg, frc_if and frc_ram
module frc_dp #(
    parameter int RING_DEPTH = frc_pkg::DEF_RING_DEPTH,
    parameter int WORD_SPACE = frc_pkg::DEF_WORD_SPACE
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  frc_pkg::cmd_t              cmd,
    output frc_pkg::status_t           status,
    input  logic [frc_pkg::WORD_W-1:0] in_word,
    frc_result_if.source               rsp,
    frc_cfg_if.sink                    cfg
);

    localparam int WW      = frc_pkg::WORD_W;
    localparam int PA_W    = $clog2(WORD_SPACE);
    localparam int RA_W    = $clog2(RING_DEPTH);
    localparam int OC_W    = $clog2(RING_DEPTH + 1);
    localparam int CMP_W   = (OC_W > frc_pkg::CAP_W) ? OC_W : frc_pkg::CAP_W;
    localparam int RED_N   = frc_pkg::red_steps(WORD_SPACE);
    localparam int RED_TOP = (RED_N > 0) ? RED_N - 1 : 0;
    localparam int RS_W    = (RED_TOP > 0) ? $clog2(RED_TOP + 1) : 1;

    localparam logic [CMP_W-1:0] CAP_LIM = CMP_W'(RING_DEPTH - 1);

    // control state
    logic [PA_W-1:0]          clr_addr_reg, clr_addr_next;
    logic [RA_W-1:0]          head_reg, head_next;
    logic [RA_W-1:0]          tail_reg, tail_next;
    logic [OC_W-1:0]          occ_reg, occ_next;
    logic [OC_W-1:0]          eff_cap_reg, eff_cap_next;
    logic [frc_pkg::CNT_W-1:0] misses_reg, misses_next;
    logic                     out_valid_reg, out_valid_next;

    // payload state
    logic [WW-1:0]            word_reg, word_next;
    logic [RS_W-1:0]          red_cnt_reg, red_cnt_next;
    logic                     hit_reg, hit_next;
    logic                     evv_reg, evv_next;
    logic [WW-1:0]            evw_reg, evw_next;
    logic                     out_hit_reg;
    logic                     out_evv_reg;
    logic [WW-1:0]            out_evw_reg;
    logic [frc_pkg::CNT_W-1:0] out_cnt_reg;

    logic [WW-1:0]            red_sub;
    logic                     pres_we;
    logic [PA_W-1:0]          pres_waddr;
    logic                     pres_rdata;
    logic [WW-1:0]            ring_rdata;

    frc_ram #(
        .WIDTH (1),
        .DEPTH (WORD_SPACE)
    ) u_present (
        .clk   (clk),
        .we    (pres_we),
        .waddr (pres_waddr),
        .wdata (cmd.append),
        .re    (cmd.look),
        .raddr (PA_W'(word_reg)),
        .rdata (pres_rdata)
    );

    frc_ram #(
        .WIDTH (WW),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (cmd.append),
        .waddr (tail_reg),
        .wdata (word_reg),
        .re    (cmd.evict_rd),
        .raddr (head_reg),
        .rdata (ring_rdata)
    );

    // presence writes: clearing pass, set on append, clear on eviction
    always_comb
    begin
        pres_we = cmd.clr_step || cmd.append || cmd.evict_wr;
        priority if (cmd.clr_step)
        begin
            pres_waddr = clr_addr_reg;
        end
        else if (cmd.append)
        begin
            pres_waddr = PA_W'(word_reg);
        end
        else
        begin
            pres_waddr = PA_W'(ring_rdata);
        end
    end

    // one restoring compare-subtract per step, highest multiple first
    assign red_sub = WW'(WORD_SPACE) << red_cnt_reg;

    always_comb
    begin
        word_next    = word_reg;
        red_cnt_next = red_cnt_reg;
        if (cmd.accept)
        begin
            word_next    = in_word;
            red_cnt_next = RS_W'(RED_TOP);
        end
        else if (cmd.red_step)
        begin
            if (word_reg >= red_sub)
            begin
                word_next = word_reg - red_sub;
            end
            red_cnt_next = red_cnt_reg - RS_W'(1);
        end
    end

    always_comb
    begin
        clr_addr_next = cmd.clr_step ? clr_addr_reg + PA_W'(1) : clr_addr_reg;

        hit_next = hit_reg;
        evv_next = evv_reg;
        evw_next = evw_reg;
        if (cmd.accept)
        begin
            hit_next = 1'b0;
            evv_next = 1'b0;
            evw_next = '0;
        end
        if (cmd.decide)
        begin
            hit_next = pres_rdata;
        end
        if (cmd.evict_wr)
        begin
            evv_next = 1'b1;
            evw_next = ring_rdata;
        end

        misses_next = misses_reg;
        if (cmd.append && (misses_reg != frc_pkg::MISS_MAX))
        begin
            misses_next = misses_reg + frc_pkg::CNT_W'(1);
        end

        tail_next = tail_reg;
        if (cmd.append)
        begin
            tail_next = (tail_reg == RA_W'(RING_DEPTH - 1)) ? '0 : tail_reg + RA_W'(1);
        end
        head_next = head_reg;
        if (cmd.evict_rd)
        begin
            head_next = (head_reg == RA_W'(RING_DEPTH - 1)) ? '0 : head_reg + RA_W'(1);
        end

        occ_next = occ_reg;
        priority if (cmd.append)
        begin
            occ_next = occ_reg + OC_W'(1);
        end
        else if (cmd.evict_rd)
        begin
            occ_next = occ_reg - OC_W'(1);
        end

        // effective capacity is clamped so the ring always has a free slot for a new miss
        eff_cap_next = eff_cap_reg;
        if (cfg.valid)
        begin
            eff_cap_next = (CMP_W'(cfg.capacity) > CAP_LIM) ? OC_W'(CAP_LIM)
                                                           : OC_W'(cfg.capacity);
        end

        out_valid_next = out_valid_reg;
        priority if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            eff_cap_reg   <= OC_W'(1);
            misses_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_addr_reg  <= clr_addr_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
            eff_cap_reg   <= eff_cap_next;
            misses_reg    <= misses_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg    <= word_next;
        red_cnt_reg <= red_cnt_next;
        hit_reg     <= hit_next;
        evv_reg     <= evv_next;
        evw_reg     <= evw_next;
        if (cmd.load_out)
        begin
            out_hit_reg <= hit_next;
            out_evv_reg <= evv_next;
            out_evw_reg <= evw_next;
            out_cnt_reg <= misses_next;
        end
    end

    assign status.clr_last = (clr_addr_reg == PA_W'(WORD_SPACE - 1));
    assign status.red_skip = (RED_N == 0);
    assign status.red_last = (red_cnt_reg == '0);
    assign status.hit      = pres_rdata;
    assign status.over_cap = (occ_reg > eff_cap_reg);
    assign status.out_free = !out_valid_reg || rsp.ready;

    assign cfg.ready = 1'b1;

    assign rsp.valid         = out_valid_reg;
    assign rsp.hit           = out_hit_reg;
    assign rsp.evicted_valid = out_evv_reg;
    assign rsp.evicted_word  = out_evw_reg;
    assign rsp.miss_count    = out_cnt_reg;

endmodule

>>> tb/frc_checker.sv
`timescale 1ns / 100ps
// result checker for the fifo replacement cache: watches the three channels and keeps its own cache image
// depends on frc_pkg; instantiated beside the block by fifo_replacement_cache_miss_counter_tb
module frc_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    input  logic                       req_ready,
    input  logic [frc_pkg::WORD_W-1:0] req_word,
    input  logic                       rsp_valid,
    input  logic                       rsp_ready,
    input  logic                       rsp_hit,
    input  logic                       rsp_evicted_valid,
    input  logic [frc_pkg::WORD_W-1:0] rsp_evicted_word,
    input  logic [frc_pkg::CNT_W-1:0]  rsp_miss_count,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [frc_pkg::CAP_W-1:0]  cfg_capacity,
    output int                         fails,
    output int                         pending,
    output int                         lookups_seen,
    output int                         hits_seen,
    output int                         evictions_seen
);
    import frc_pkg::*;

    localparam int RING  = DEF_RING_DEPTH;
    localparam int SPACE = DEF_WORD_SPACE;

    typedef struct packed {
        logic              hit;
        logic              evicted_valid;
        logic [WORD_W-1:0] evicted_word;
        logic [CNT_W-1:0]  miss_count;
    } lookup_result_t;

    // cache image
    logic [CAP_W-1:0]  capacity_q;
    logic [SPACE-1:0]  present_map;
    logic [WORD_W-1:0] ring_words [RING];
    int                oldest_slot;
    int                free_slot;
    int                fill;
    logic [CNT_W-1:0]  miss_total;

    lookup_result_t    lookup_q [$];
    lookup_result_t    want;

    function automatic lookup_result_t predict_lookup(input logic [WORD_W-1:0] raw);
        lookup_result_t r;
        int             w;
        int             limit;
        int             old;
        r     = '0;
        w     = int'(raw) % SPACE;
        limit = (int'(capacity_q) < RING - 1) ? int'(capacity_q) : RING - 1;
        if (present_map[w])
        begin
            r.hit = 1'b1;
        end
        else
        begin
            if (miss_total != MISS_MAX)
            begin
                miss_total = miss_total + 1'b1;
            end
            ring_words[free_slot] = WORD_W'(w);
            free_slot             = (free_slot + 1) % RING;
            fill                  = fill + 1;
            present_map[w]        = 1'b1;
            // drain oldest entries down to the capacity, report the last one
            while (fill > limit)
            begin
                old              = int'(ring_words[oldest_slot]) % SPACE;
                oldest_slot      = (oldest_slot + 1) % RING;
                fill             = fill - 1;
                present_map[old] = 1'b0;
                r.evicted_valid  = 1'b1;
                r.evicted_word   = WORD_W'(old);
            end
        end
        r.miss_count = miss_total;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [CNT_W-1:0] exp_v,
                                        input logic [CNT_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            fails = fails + 1;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_q     = CAP_W'(1);
            present_map    = '0;
            oldest_slot    = 0;
            free_slot      = 0;
            fill           = 0;
            miss_total     = '0;
            lookup_q.delete();
            fails          = 0;
            pending        = 0;
            lookups_seen   = 0;
            hits_seen      = 0;
            evictions_seen = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                capacity_q = cfg_capacity;
            end
            if (req_valid && req_ready)
            begin
                lookup_q.push_back(predict_lookup(req_word));
            end
            if (rsp_valid && rsp_ready)
            begin
                lookups_seen = lookups_seen + 1;
                if (lookup_q.size() == 0)
                begin
                    fails = fails + 1;
                    $display("%0t: unexpected result, expected none, actual hit=%0b ev=%0b word=%0d count=%0d",
                             $time, rsp_hit, rsp_evicted_valid, rsp_evicted_word, rsp_miss_count);
                end
                else
                begin
                    want = lookup_q.pop_front();
                    hits_seen      = hits_seen + int'(want.hit);
                    evictions_seen = evictions_seen + int'(want.evicted_valid);
                    check_field("hit", CNT_W'(want.hit), CNT_W'(rsp_hit));
                    check_field("evicted_valid", CNT_W'(want.evicted_valid),
                                CNT_W'(rsp_evicted_valid));
                    check_field("evicted_word", CNT_W'(want.evicted_word),
                                CNT_W'(rsp_evicted_word));
                    check_field("miss_count", want.miss_count, rsp_miss_count);
                end
            end
            pending = lookup_q.size();
        end
    end

endmodule

>>> tb/fifo_replacement_cache_miss_counter_tb.sv
`timescale 1ns / 100ps
// top of the fifo replacement cache testbench: clock, reset, lookup and capacity stimulus, verdict
// depends on frc_pkg, frc_if, the block and frc_checker
module fifo_replacement_cache_miss_counter_tb;
    import frc_pkg::*;

    // how the words of a phase are picked
    typedef enum logic [1:0] {
        MIX_POOL,    // mostly a small set of words, lots of hits
        MIX_RANDOM,  // anywhere in the word space, mostly misses
        MIX_SWEEP    // ascending words with a few repeats, fills the ring
    } word_mix_t;

    logic clk;
    logic rst_n;
    logic steady;          // when set neither side idles
    logic [WORD_W-1:0] sweep_word;
    int   settings_used;

    int fails;
    int pending;
    int lookups_seen;
    int hits_seen;
    int evictions_seen;

    frc_word_if   req_ch ();
    frc_result_if rsp_ch ();
    frc_cfg_if    cfg_ch ();

    fifo_replacement_cache_miss_counter u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    frc_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .req_valid         (req_ch.valid),
        .req_ready         (req_ch.ready),
        .req_word          (req_ch.word),
        .rsp_valid         (rsp_ch.valid),
        .rsp_ready         (rsp_ch.ready),
        .rsp_hit           (rsp_ch.hit),
        .rsp_evicted_valid (rsp_ch.evicted_valid),
        .rsp_evicted_word  (rsp_ch.evicted_word),
        .rsp_miss_count    (rsp_ch.miss_count),
        .cfg_valid         (cfg_ch.valid),
        .cfg_ready         (cfg_ch.ready),
        .cfg_capacity      (cfg_ch.capacity),
        .fails             (fails),
        .pending           (pending),
        .lookups_seen      (lookups_seen),
        .hits_seen         (hits_seen),
        .evictions_seen    (evictions_seen)
    );

    // 20 ns clock
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // result side: back-pressure in about a fifth of the cycles, none while steady
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 20);
        end
    end

    // hard stop in case the block hangs; far above the slowest legal run
    initial
    begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // offer one lookup item, called and returning at a falling edge; valid is left high
    // so the next call can keep it up or drop it, one assignment per edge either way
    task automatic send_word(input logic [WORD_W-1:0] w);
        while (!steady && $urandom_range(0, 99) < 20)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.word  <= w;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // drop valid and wait until every expected result is back, then let the block go idle
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    // capacity write; only called while the cache is idle
    task automatic cap_write(input logic [CAP_W-1:0] cap);
        cfg_ch.valid    <= 1'b1;
        cfg_ch.capacity <= cap;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_ch.valid  <= 1'b0;
        settings_used = settings_used + 1;
    endtask

    // one capacity setting followed by a run of random lookups
    task automatic run_phase(input logic [CAP_W-1:0] cap, input int count,
                             input word_mix_t mix);
        logic [WORD_W-1:0] w;
        cap_write(cap);
        for (int i = 0; i < count; i++)
        begin
            // long quiet-free stretch in the middle of the ring fill
            steady = (mix == MIX_SWEEP) && (i >= 300) && (i < 600);
            case (mix)
                MIX_POOL:
                begin
                    if ($urandom_range(0, 99) < 85)
                        w = WORD_W'($urandom_range(0, 15));
                    else
                        w = WORD_W'($urandom_range(0, WORD_MAX));
                end
                MIX_RANDOM:
                begin
                    w = WORD_W'($urandom_range(0, WORD_MAX));
                end
                default:
                begin
                    // mostly the next new word, now and then a recent one again
                    if ($urandom_range(0, 99) < 95)
                    begin
                        w          = sweep_word;
                        sweep_word = sweep_word + 1'b1;
                    end
                    else
                    begin
                        w = sweep_word - WORD_W'($urandom_range(1, 8));
                    end
                end
            endcase
            send_word(w);
        end
        steady = 1'b0;
        settle();
    endtask

    initial
    begin
        // every input known and reset held low from time zero
        rst_n           = 1'b0;
        steady          = 1'b0;
        sweep_word      = '0;
        settings_used   = 0;
        req_ch.valid    = 1'b0;
        req_ch.word     = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.capacity = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // reset capacity of one: hit on repeat, each new word pushes out the last,
        // extreme word values on both sides
        send_word(WORD_W'(0));
        send_word(WORD_W'(0));
        send_word(WORD_W'(WORD_MAX));
        send_word(WORD_W'(0));
        send_word(WORD_W'(WORD_MAX));
        send_word(WORD_W'(10'h155));
        send_word(WORD_W'(10'h2aa));
        settle();

        // capacity zero: the held word hits until the first miss drains it, after that
        // every lookup misses and comes back as its own eviction
        cap_write(CAP_W'(0));
        send_word(WORD_W'(10'h2aa));
        send_word(WORD_W'(10'h2aa));
        send_word(WORD_W'(WORD_MAX));
        settle();

        // largest register value, which is exactly one below the ring depth
        cap_write(CAP_W'((1 << CAP_W) - 1));
        send_word(WORD_W'(10'h001));
        send_word(WORD_W'(10'h002));
        send_word(WORD_W'(10'h200));
        send_word(WORD_W'(10'h100));
        send_word(WORD_W'(10'h001));
        send_word(WORD_W'(WORD_MAX));
        settle();

        // capacity dropped under the fill: a hit leaves it, the next miss drains
        // several and reports the last one
        cap_write(CAP_W'(2));
        send_word(WORD_W'(10'h002));
        send_word(WORD_W'(10'h080));
        send_word(WORD_W'(10'h040));
        settle();

        // random phases across small, zero, one, mid, max and one-below-max settings
        run_phase(CAP_W'($urandom_range(2, 8)), 40, MIX_POOL);
        run_phase(CAP_W'(0), 30, MIX_POOL);
        run_phase(CAP_W'(1), 30, MIX_POOL);
        run_phase(CAP_W'($urandom_range(300, 600)), 40, MIX_RANDOM);
        sweep_word = WORD_W'($urandom_range(0, WORD_MAX));
        run_phase(CAP_W'((1 << CAP_W) - 1), 1100, MIX_SWEEP);
        // near-full ring cut down to three in one miss
        run_phase(CAP_W'(3), 30, MIX_POOL);
        run_phase(CAP_W'(DEF_RING_DEPTH - 2), 30, MIX_RANDOM);

        repeat (12) @(negedge clk);

        $display("run covered %0d lookups: %0d hits, %0d with an eviction", lookups_seen,
                 hits_seen, evictions_seen);
        $display("capacity written %0d times, from zero up to the register maximum",
                 settings_used);
        if (fails == 0 && pending == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> fifo_replacement_cache_miss_counter.f
rtl/core/frc_pkg.sv
rtl/core/frc_if.sv
rtl/core/frc_ram.sv
rtl/core/frc_ctrl.sv
rtl/core/frc_dp.sv
rtl/core/fifo_replacement_cache_miss_counter.sv
tb/frc_checker.sv
tb/fifo_replacement_cache_miss_counter_tb.sv
